FILE: src/stf_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the scanline triangle fill block.
// No dependencies; every other file but stf_div refers to it by scoped names.
package stf_pkg;

    // Coordinate width, fixed by the port fields
    localparam int COORD_BITS = 12;

    typedef struct packed {
        logic                          cmd;
        logic signed [COORD_BITS-1:0]  ax;
        logic signed [COORD_BITS-1:0]  ay;
        logic signed [COORD_BITS-1:0]  bx;
        logic signed [COORD_BITS-1:0]  by;
        logic signed [COORD_BITS-1:0]  cx;
        logic signed [COORD_BITS-1:0]  cy;
        logic [31:0]                   fill_color;
    } in_beat_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0]  row;
        logic signed [COORD_BITS-1:0]  span_xa;
        logic signed [COORD_BITS-1:0]  span_xb;
        logic [31:0]                   span_color;
        logic                          last_span;
    } out_beat_t;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_BOTTOM = 3'b010,
        PH_TOP    = 3'b100
    } phase_t;

    // Which quotient the divider computes
    typedef enum logic [2:0] {
        DIV_SPLIT = 3'd0,
        DIV_BOT0  = 3'd1,
        DIV_BOT1  = 3'd2,
        DIV_TOP0  = 3'd3,
        DIV_TOP1  = 3'd4
    } div_sel_t;

    typedef enum logic [1:0] {
        SPL_X2  = 2'd0,
        SPL_X1  = 2'd1,
        SPL_QUO = 2'd2
    } split_src_t;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic       div_start;
        div_sel_t   div_sel;
        logic       split_en;
        split_src_t split_src;
        logic       slope0_en;
        logic       slope1_en;
        logic       init_bot;
        logic       init_top;
        logic       step_down;
        logic       step_up;
        logic       out_load;
        logic       out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic eq01;
        logic eq12;
        logic row_ge_y1;
        logic row_le_y1;
        logic div_done;
    } dp_status_t;

endpackage

FILE: src/stf_div.sv
`timescale 1ns / 1ps
// Signed-by-positive restoring divider, one quotient bit per cycle,
// truncating toward zero. Standalone; no package use.
module stf_div #(
    parameter int DW = 29,
    parameter int VW = 13
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic signed [DW-1:0] dividend,
    input  logic [VW-1:0]        divisor,
    output logic                 done,
    output logic signed [DW-1:0] quotient
);
    localparam int CW = (DW > 1) ? $clog2(DW) : 1;

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic          neg_reg;
    logic [DW-1:0] mag_reg;
    logic [VW:0]   rem_reg;
    logic [VW-1:0] dvs_reg;
    logic [DW-1:0] quo_reg;

    logic [VW+1:0] trial;
    logic [VW+1:0] diff;
    logic          qbit;
    logic [VW:0]   rem_next;
    logic [DW-1:0] mag_next;

    // One restoring step
    always_comb begin
        trial    = {rem_reg, mag_reg[DW-1]};
        diff     = trial - {2'b00, dvs_reg};
        qbit     = (trial >= {2'b00, dvs_reg});
        rem_next = qbit ? diff[VW:0] : trial[VW:0];
        mag_next = {mag_reg[DW-2:0], qbit};
    end

    // Sequence the iterations
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(DW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operands and partial results
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[DW-1];
            mag_reg <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            mag_reg <= mag_next;
            rem_reg <= rem_next;
            if (cnt_reg == CW'(DW - 1)) begin
                quo_reg <= neg_reg ? DW'(-mag_next) : mag_next;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = signed'(quo_reg);
endmodule

FILE: src/stf_datapath.sv
`timescale 1ns / 1ps
// Datapath: sorted vertices, split x, edge slopes and accumulators, span output register.
// Depends on stf_pkg and stf_div.
module stf_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  stf_pkg::in_beat_t   in_beat,
    input  stf_pkg::dp_cmd_t    cmd,
    output stf_pkg::dp_status_t status,
    output stf_pkg::out_beat_t  out_beat
);
    localparam int C  = stf_pkg::COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int AW = C + F + 2;
    localparam int PW = 2 * C + 2;
    localparam int DW = (PW > C + 1 + F) ? PW : C + 1 + F;
    localparam logic signed [AW-1:0] SMAX = AW'((2 ** (C - 1)) - 1);
    localparam logic signed [AW-1:0] SMIN = ~SMAX;

    logic signed [C-1:0]  x0_reg, y0_reg, x1_reg, y1_reg, x2_reg, y2_reg;
    logic [31:0]          color_reg;
    logic signed [C-1:0]  split_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [AW-1:0] acc0_reg, acc1_reg, slope0_reg, slope1_reg;
    logic signed [C-1:0]  row_reg;
    stf_pkg::out_beat_t   out_reg;

    // Sort vertices by y with three compare-and-swap steps
    logic signed [C-1:0] sx [3];
    logic signed [C-1:0] sy [3];
    logic signed [C-1:0] tx, ty;
    always_comb begin
        tx = '0; ty = '0;
        sx[0] = in_beat.ax; sy[0] = in_beat.ay;
        sx[1] = in_beat.bx; sy[1] = in_beat.by;
        sx[2] = in_beat.cx; sy[2] = in_beat.cy;
        if (sy[0] > sy[1]) begin
            tx = sx[0]; ty = sy[0]; sx[0] = sx[1]; sy[0] = sy[1]; sx[1] = tx; sy[1] = ty;
        end
        if (sy[1] > sy[2]) begin
            tx = sx[1]; ty = sy[1]; sx[1] = sx[2]; sy[1] = sy[2]; sx[2] = tx; sy[2] = ty;
        end
        if (sy[0] > sy[1]) begin
            tx = sx[0]; ty = sy[0]; sx[0] = sx[1]; sy[0] = sy[1]; sx[1] = tx; sy[1] = ty;
        end
    end

    // Divider operands
    logic signed [C:0]    dx;
    logic [C:0]           dy;
    logic signed [DW-1:0] div_dvd;
    logic                 div_done;
    logic signed [DW-1:0] div_quo;
    logic signed [C-1:0]  far_a;

    always_comb begin
        far_a = (y0_reg == y1_reg) ? x0_reg : x1_reg;
        case (cmd.div_sel)
            stf_pkg::DIV_BOT0: dx = (C+1)'(x1_reg) - (C+1)'(x0_reg);
            stf_pkg::DIV_BOT1: dx = (C+1)'(split_reg) - (C+1)'(x0_reg);
            stf_pkg::DIV_TOP0: dx = (C+1)'(x2_reg) - (C+1)'(far_a);
            stf_pkg::DIV_TOP1: dx = (C+1)'(x2_reg) - (C+1)'(split_reg);
            default:           dx = '0;
        endcase
        case (cmd.div_sel)
            stf_pkg::DIV_BOT0, stf_pkg::DIV_BOT1:
                dy = (C+1)'(unsigned'((C+1)'(y1_reg) - (C+1)'(y0_reg)));
            stf_pkg::DIV_TOP0, stf_pkg::DIV_TOP1:
                dy = (C+1)'(unsigned'((C+1)'(y2_reg) - (C+1)'(y1_reg)));
            default:
                dy = (C+1)'(unsigned'((C+1)'(y2_reg) - (C+1)'(y0_reg)));
        endcase
        if (cmd.div_sel == stf_pkg::DIV_SPLIT) begin
            div_dvd = DW'(prod_reg);
        end else begin
            div_dvd = DW'(dx) <<< F;
        end
    end

    stf_div #(.DW(DW), .VW(C + 1)) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dvd),
        .divisor  (dy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Span ends: truncate toward zero, then saturate
    function automatic logic signed [C-1:0] span_end(input logic signed [AW-1:0] acc);
        logic signed [AW-1:0] t;
        t = acc >>> F;
        if (acc[AW-1] && (acc[F-1:0] != '0)) begin
            t = t + AW'(1);
        end
        if (t > SMAX) begin
            t = SMAX;
        end else if (t < SMIN) begin
            t = SMIN;
        end
        return t[C-1:0];
    endfunction

    // Vertex, colour, split and product registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x0_reg <= '0; y0_reg <= '0; x1_reg <= '0;
            y1_reg <= '0; x2_reg <= '0; y2_reg <= '0;
            color_reg <= '0;
            split_reg <= '0;
        end else begin
            if (cmd.load) begin
                x0_reg <= sx[0]; y0_reg <= sy[0];
                x1_reg <= sx[1]; y1_reg <= sy[1];
                x2_reg <= sx[2]; y2_reg <= sy[2];
                color_reg <= in_beat.fill_color;
            end
            if (cmd.split_en) begin
                case (cmd.split_src)
                    stf_pkg::SPL_X2: split_reg <= x2_reg;
                    stf_pkg::SPL_X1: split_reg <= x1_reg;
                    default:         split_reg <= div_quo[C-1:0] + x0_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= ((C+1)'(x2_reg) - (C+1)'(x0_reg)) *
                        ((C+1)'(y1_reg) - (C+1)'(y0_reg));
        end
    end

    // Edge slopes, accumulators and current row
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc0_reg <= '0; acc1_reg <= '0;
            slope0_reg <= '0; slope1_reg <= '0;
            row_reg <= '0;
        end else begin
            if (cmd.slope0_en) slope0_reg <= AW'(div_quo);
            if (cmd.slope1_en) slope1_reg <= AW'(div_quo);
            if (cmd.init_bot) begin
                acc0_reg <= AW'(x0_reg) <<< F;
                acc1_reg <= AW'(x0_reg) <<< F;
                row_reg  <= y0_reg;
            end else if (cmd.init_top) begin
                acc0_reg <= AW'(x2_reg) <<< F;
                acc1_reg <= AW'(x2_reg) <<< F;
                row_reg  <= y2_reg;
            end else if (cmd.step_down) begin
                acc0_reg <= acc0_reg + slope0_reg;
                acc1_reg <= acc1_reg + slope1_reg;
                row_reg  <= row_reg + C'(1);
            end else if (cmd.step_up) begin
                acc0_reg <= acc0_reg - slope0_reg;
                acc1_reg <= acc1_reg - slope1_reg;
                row_reg  <= row_reg - C'(1);
            end
        end
    end

    // Hold the outgoing span until taken
    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_reg.row        <= row_reg;
            out_reg.span_xa    <= span_end(acc0_reg);
            out_reg.span_xb    <= span_end(acc1_reg);
            out_reg.span_color <= color_reg;
            out_reg.last_span  <= cmd.out_last;
        end
    end

    assign status.eq01      = (y0_reg == y1_reg);
    assign status.eq12      = (y1_reg == y2_reg);
    assign status.row_ge_y1 = (row_reg >= y1_reg);
    assign status.row_le_y1 = (row_reg <= y1_reg);
    assign status.div_done  = div_done;
    assign out_beat         = out_reg;
endmodule

FILE: src/stf_ctrl.sv
`timescale 1ns / 1ps
// Controller: handshakes, triangle setup sequence and span phase tracking.
// Depends on stf_pkg.
module stf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_cmd,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  stf_pkg::dp_status_t status,
    output stf_pkg::dp_cmd_t    cmd
);
    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_CLASS  = 7'b0000010,
        ST_MUL    = 7'b0000100,
        ST_WSPLIT = 7'b0001000,
        ST_START  = 7'b0010000,
        ST_WS0    = 7'b0100000,
        ST_WS1    = 7'b1000000
    } state_t;

    state_t          state_reg, state_next;
    stf_pkg::phase_t phase_reg, phase_next;
    logic            mvalid_reg, mvalid_next;
    logic            accept;

    assign s_ready = (state_reg == ST_IDLE) && (!mvalid_reg || m_ready);
    assign accept  = s_valid && s_ready;
    assign m_valid = mvalid_reg;

    // Next state and datapath commands
    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        mvalid_next = mvalid_reg && !m_ready;
        cmd         = '0;
        cmd.div_sel = stf_pkg::DIV_SPLIT;
        cmd.split_src = stf_pkg::SPL_X2;
        case (state_reg)
            ST_IDLE: begin
                if (accept && s_cmd == stf_pkg::CMD_LOAD) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CLASS;
                end else if (accept && phase_reg != stf_pkg::PH_IDLE) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    if (phase_reg == stf_pkg::PH_BOTTOM) begin
                        if (status.row_ge_y1) begin
                            if (!status.eq12) begin
                                cmd.init_top  = 1'b1;
                                cmd.div_start = 1'b1;
                                cmd.div_sel   = stf_pkg::DIV_TOP0;
                                phase_next    = stf_pkg::PH_TOP;
                                state_next    = ST_WS0;
                            end else begin
                                cmd.out_last = 1'b1;
                                phase_next   = stf_pkg::PH_IDLE;
                            end
                        end else begin
                            cmd.step_down = 1'b1;
                        end
                    end else begin
                        if (status.row_le_y1) begin
                            cmd.out_last = 1'b1;
                            phase_next   = stf_pkg::PH_IDLE;
                        end else begin
                            cmd.step_up = 1'b1;
                        end
                    end
                end
            end
            ST_CLASS: begin
                if (status.eq01 && status.eq12) begin
                    cmd.split_en  = 1'b1;
                    cmd.split_src = stf_pkg::SPL_X2;
                    phase_next    = stf_pkg::PH_IDLE;
                    state_next    = ST_IDLE;
                end else if (status.eq12) begin
                    cmd.split_en  = 1'b1;
                    cmd.split_src = stf_pkg::SPL_X2;
                    state_next    = ST_START;
                end else if (status.eq01) begin
                    cmd.split_en  = 1'b1;
                    cmd.split_src = stf_pkg::SPL_X1;
                    state_next    = ST_START;
                end else begin
                    cmd.mul_en = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = stf_pkg::DIV_SPLIT;
                state_next    = ST_WSPLIT;
            end
            ST_WSPLIT: begin
                if (status.div_done) begin
                    cmd.split_en  = 1'b1;
                    cmd.split_src = stf_pkg::SPL_QUO;
                    state_next    = ST_START;
                end
            end
            ST_START: begin
                cmd.div_start = 1'b1;
                if (!status.eq01) begin
                    cmd.div_sel  = stf_pkg::DIV_BOT0;
                    cmd.init_bot = 1'b1;
                    phase_next   = stf_pkg::PH_BOTTOM;
                end else begin
                    cmd.div_sel  = stf_pkg::DIV_TOP0;
                    cmd.init_top = 1'b1;
                    phase_next   = stf_pkg::PH_TOP;
                end
                state_next = ST_WS0;
            end
            ST_WS0: begin
                if (phase_reg == stf_pkg::PH_BOTTOM) begin
                    cmd.div_sel = stf_pkg::DIV_BOT1;
                end else begin
                    cmd.div_sel = stf_pkg::DIV_TOP1;
                end
                if (status.div_done) begin
                    cmd.slope0_en = 1'b1;
                    cmd.div_start = 1'b1;
                    state_next    = ST_WS1;
                end
            end
            ST_WS1: begin
                if (status.div_done) begin
                    cmd.slope1_en = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            phase_reg  <= stf_pkg::PH_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            mvalid_reg <= mvalid_next;
        end
    end
endmodule

FILE: src/scanline_triangle_fill.sv
`timescale 1ns / 1ps
// Scanline triangle fill: a load beat sorts the vertices and sets up the edges,
// then each step beat returns one span while a triangle runs. The setup uses
// one shared divider of D = max(2*COORD_BITS+2, COORD_BITS+1+FRAC_BITS) bits
// (29 at the defaults). A load with both halves spends one split divide and two
// slope divides before the next beat is taken; a load with one flat half spends
// two slope divides; a load with all three rows equal spends no divide. The step
// that crosses into the lower half spends two more divides before the next beat
// is taken. A finished span waits in an output register; the next beat is taken
// only once that span leaves, at the earliest in the same cycle. Depends on
// stf_pkg, stf_ctrl, stf_datapath.
module scanline_triangle_fill #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  stf_pkg::in_beat_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output stf_pkg::out_beat_t m_data
);
    stf_pkg::dp_cmd_t    cmd;
    stf_pkg::dp_status_t status;

    stf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_data.cmd),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    stf_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_beat  (s_data),
        .cmd      (cmd),
        .status   (status),
        .out_beat (m_data)
    );
endmodule

FILE: tb/scanline_triangle_fill_tb.sv
`timescale 1ns / 1ps
// Testbench for scanline_triangle_fill: drives load and step beats, predicts
// each span in a local triangle walker, and compares spans field by field.
// Depends on stf_pkg and the scanline_triangle_fill RTL.
module scanline_triangle_fill_tb;

    localparam int  FRAC = 16;
    localparam int  CB = stf_pkg::COORD_BITS;
    localparam longint ONE_FX = 64'sd1 << FRAC;
    localparam longint CMAX_V = (64'sd1 << (CB - 1)) - 1;
    localparam longint CMIN_V = -(64'sd1 << (CB - 1));

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    stf_pkg::in_beat_t   s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    stf_pkg::out_beat_t  m_data;

    scanline_triangle_fill #(.FRAC_BITS(FRAC)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always #5 aclk = ~aclk;

    // Predictor state of the triangle walker
    longint  vtx_x[3], vtx_y[3];
    longint  split_xv, acc_a, acc_b, slope_a, slope_b, cur_row;
    stf_pkg::phase_t walk_phase = stf_pkg::PH_IDLE;
    logic [31:0] walk_color = '0;

    stf_pkg::in_beat_t  pending_beats[$];
    stf_pkg::out_beat_t expected_spans[$];
    int        mismatch_count = 0;
    int        send_idle_pct = 12;
    int        recv_idle_pct = 50;
    bit        s_ready_seen = 1'b0;
    bit        hold_sender = 1'b0;

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    function automatic longint clip_end(input longint acc);
        longint t;
        t = acc / ONE_FX;
        if (t > CMAX_V) t = CMAX_V;
        if (t < CMIN_V) t = CMIN_V;
        return t;
    endfunction

    function automatic void enter_lower_half();
        longint far_a;
        far_a = (vtx_y[0] == vtx_y[1]) ? vtx_x[0] : vtx_x[1];
        slope_a = ((vtx_x[2] - far_a) * ONE_FX) / (vtx_y[2] - vtx_y[1]);
        slope_b = ((vtx_x[2] - split_xv) * ONE_FX) / (vtx_y[2] - vtx_y[1]);
        acc_a = vtx_x[2] * ONE_FX;
        acc_b = vtx_x[2] * ONE_FX;
        cur_row = vtx_y[2];
        walk_phase = stf_pkg::PH_TOP;
    endfunction

    function automatic void sort_pair(input int i, input int j);
        longint tx, ty;
        if (vtx_y[i] > vtx_y[j]) begin
            tx = vtx_x[i]; ty = vtx_y[i];
            vtx_x[i] = vtx_x[j]; vtx_y[i] = vtx_y[j];
            vtx_x[j] = tx; vtx_y[j] = ty;
        end
    endfunction

    // Advance the walker by one accepted beat; queue the span it yields
    function automatic void predict_span(input stf_pkg::in_beat_t b);
        stf_pkg::out_beat_t sp;
        logic last;
        if (b.cmd == stf_pkg::CMD_LOAD) begin
            vtx_x[0] = b.ax; vtx_y[0] = b.ay;
            vtx_x[1] = b.bx; vtx_y[1] = b.by;
            vtx_x[2] = b.cx; vtx_y[2] = b.cy;
            walk_color = b.fill_color;
            sort_pair(0, 1); sort_pair(1, 2); sort_pair(0, 1);
            if (vtx_y[0] == vtx_y[1] && vtx_y[1] == vtx_y[2]) begin
                split_xv = vtx_x[2];
                walk_phase = stf_pkg::PH_IDLE;
                return;
            end
            if (vtx_y[1] == vtx_y[2]) split_xv = vtx_x[2];
            else if (vtx_y[0] == vtx_y[1]) split_xv = vtx_x[1];
            else split_xv = ((vtx_x[2] - vtx_x[0]) * (vtx_y[1] - vtx_y[0]))
                            / (vtx_y[2] - vtx_y[0]) + vtx_x[0];
            if (vtx_y[0] != vtx_y[1]) begin
                slope_a = ((vtx_x[1] - vtx_x[0]) * ONE_FX) / (vtx_y[1] - vtx_y[0]);
                slope_b = ((split_xv - vtx_x[0]) * ONE_FX) / (vtx_y[1] - vtx_y[0]);
                acc_a = vtx_x[0] * ONE_FX;
                acc_b = vtx_x[0] * ONE_FX;
                cur_row = vtx_y[0];
                walk_phase = stf_pkg::PH_BOTTOM;
            end else begin
                enter_lower_half();
            end
            return;
        end
        if (walk_phase == stf_pkg::PH_IDLE) return;
        sp.row = cur_row[CB-1:0];
        sp.span_xa = CB'(clip_end(acc_a));
        sp.span_xb = CB'(clip_end(acc_b));
        sp.span_color = walk_color;
        last = 1'b0;
        if (walk_phase == stf_pkg::PH_BOTTOM) begin
            if (cur_row >= vtx_y[1]) begin
                if (vtx_y[2] != vtx_y[1]) enter_lower_half();
                else begin
                    walk_phase = stf_pkg::PH_IDLE;
                    last = 1'b1;
                end
            end else begin
                cur_row++;
                acc_a += slope_a;
                acc_b += slope_b;
            end
        end else begin
            if (cur_row <= vtx_y[1]) begin
                walk_phase = stf_pkg::PH_IDLE;
                last = 1'b1;
            end else begin
                cur_row--;
                acc_a -= slope_a;
                acc_b -= slope_b;
            end
        end
        sp.last_span = last;
        expected_spans.push_back(sp);
    endfunction

    function automatic stf_pkg::in_beat_t make_load(input int xa, ya, xb, yb, xc, yc);
        stf_pkg::in_beat_t b;
        b.cmd = stf_pkg::CMD_LOAD;
        b.ax = CB'(xa); b.ay = CB'(ya); b.bx = CB'(xb);
        b.by = CB'(yb); b.cx = CB'(xc); b.cy = CB'(yc);
        b.fill_color = $urandom;
        return b;
    endfunction

    function automatic stf_pkg::in_beat_t make_step();
        stf_pkg::in_beat_t b;
        b.ax = CB'($urandom); b.ay = CB'($urandom); b.bx = CB'($urandom);
        b.by = CB'($urandom); b.cx = CB'($urandom); b.cy = CB'($urandom);
        b.fill_color = $urandom;
        b.cmd = stf_pkg::CMD_STEP;
        return b;
    endfunction

    // Random coordinate within spread of the origin, now and then a range extreme
    function automatic int pick_coord(input int spread);
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(0, 1) ? 2047 : -2048;
        return $signed($urandom_range(0, 2 * spread)) - spread;
    endfunction

    function automatic void queue_triangle(input int spread, input int extra);
        int ya, yb, yc, rows;
        ya = pick_coord(spread); yb = pick_coord(spread); yc = pick_coord(spread);
        if ($urandom_range(0, 6) == 0) yb = ya;
        if ($urandom_range(0, 6) == 0) yc = yb;
        // Keep rare full-height triangles from swamping the run
        if ((ya > yb ? ya - yb : yb - ya) > 64 || (yb > yc ? yb - yc : yc - yb) > 64)
        begin
            ya = ya % 40; yb = yb % 40; yc = yc % 40;
        end
        pending_beats.push_back(make_load(pick_coord(spread), ya,
            pick_coord(spread), yb, pick_coord(spread), yc));
        rows = 0;
        rows += (ya > yb ? ya - yb : yb - ya);
        rows += (yb > yc ? yb - yc : yc - yb);
        rows += (ya > yc ? ya - yc : yc - ya);
        rows = rows + 2 + extra;
        // Sometimes cut short so a load lands on a triangle in progress
        if ($urandom_range(0, 7) == 0) rows = $urandom_range(0, rows);
        repeat (rows) pending_beats.push_back(make_step());
    endfunction

    // Driver: present beats at the falling edge
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_valid || s_ready_seen) begin
                if (pending_beats.size() != 0 && !hold_sender &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    s_data <= pending_beats.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Sampler: accept beats and check spans at the rising edge
    always @(posedge aclk) begin
        s_ready_seen <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predict_span(s_data);
            end
            if (m_valid && m_ready) begin
                if (expected_spans.size() == 0) begin
                    report_mismatch("span with none expected");
                end else begin
                    stf_pkg::out_beat_t e;
                    e = expected_spans.pop_front();
                    if (m_data.row !== e.row)
                        report_mismatch($sformatf("row %0d exp %0d", m_data.row, e.row));
                    if (m_data.span_xa !== e.span_xa)
                        report_mismatch($sformatf("span_xa %0d exp %0d",
                                                  m_data.span_xa, e.span_xa));
                    if (m_data.span_xb !== e.span_xb)
                        report_mismatch($sformatf("span_xb %0d exp %0d",
                                                  m_data.span_xb, e.span_xb));
                    if (m_data.span_color !== e.span_color)
                        report_mismatch($sformatf("span_color %h exp %h",
                                                  m_data.span_color, e.span_color));
                    if (m_data.last_span !== e.last_span)
                        report_mismatch($sformatf("last_span %b exp %b",
                                                  m_data.last_span, e.last_span));
                end
            end
        end
    end

    task automatic wait_drained();
        while (pending_beats.size() != 0 || s_valid || expected_spans.size() != 0)
            @(posedge aclk);
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: idle step, flat halves, degenerate, extremes, replace
        pending_beats.push_back(make_step());
        pending_beats.push_back(make_load(0, 0, 5, 0, 9, 0));
        pending_beats.push_back(make_step());
        pending_beats.push_back(make_load(0, 0, -4, 3, 4, 3));
        repeat (5) pending_beats.push_back(make_step());
        pending_beats.push_back(make_load(-3, 0, 3, 0, 0, 4));
        repeat (6) pending_beats.push_back(make_step());
        pending_beats.push_back(make_load(2047, -2048, -2048, -2046, 2047, -2043));
        repeat (9) pending_beats.push_back(make_step());
        pending_beats.push_back(make_load(-7, 5, 11, -2, 1, 2));
        repeat (3) pending_beats.push_back(make_load(10, 1, -5, 6, -10, -2));
        pending_beats.push_back(make_step());
        pending_beats.push_back(make_load(-2048, 2047, 2047, 2045, -2048, 2046));
        repeat (5) pending_beats.push_back(make_step());
        wait_drained();

        // Random phases with different idling mixes
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 50 : 0;
            recv_idle_pct = (ph == 0) ? 50 : (ph == 1) ? 12 : 0;
            for (int k = 0; k < 15; k++) begin
                queue_triangle($urandom_range(0, 3) == 0 ? 2047 : 12,
                               $urandom_range(0, 2));
                while (pending_beats.size() > 8) @(posedge aclk);
                if (k == 10) begin
                    // Let every span drain before going on
                    hold_sender = 1'b1;
                    while (s_valid || expected_spans.size() != 0) @(posedge aclk);
                    hold_sender = 1'b0;
                end
            end
            wait_drained();
        end
        repeat (200) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end
endmodule
